@@ rtl/neighbor_table_with_aging_unit_macros.svh @@
// Assertion helpers for the RTL.
`ifndef NEIGHBOR_TABLE_WITH_AGING_UNIT_MACROS_SVH
`define NEIGHBOR_TABLE_WITH_AGING_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define NT_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define NT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/nt_pkg.sv @@
package nt_pkg;

  localparam int NT_MAX_ENTRIES   = 16;
  localparam int NT_HISTORY_DEPTH = 4;

  // Fixed field widths
  localparam int NT_ID_W   = 16;
  localparam int NT_DIST_W = 8;
  localparam int NT_BYTE_W = 8;
  localparam int NT_GRAD_W = 16;
  localparam int NT_TIME_W = 32;
  localparam int NT_OUT_W  = 4;

  // Register port
  localparam int NT_ADDR_W = 3;
  localparam int NT_DATA_W = 32;
  localparam logic [NT_TIME_W-1:0] NT_AGE_LIMIT_RST = 32'd64;
  localparam logic REG_AGE_LIMIT = 1'b0;  // word index, paddr[2]

  // Item actions
  localparam logic ACT_MSG   = 1'b0;
  localparam logic ACT_PURGE = 1'b1;

  typedef struct packed {
    logic latch;     // capture input item, clear result flags
    logic idx_clr;
    logic idx_inc;
    logic idx_top;   // idx <= count - 1
    logic idx_dec;
    logic rd_last;   // read the last record instead of idx
    logic wr_upd;    // refresh record at idx from read data
    logic wr_new;    // append record at idx
    logic wr_move;   // copy read record into idx, shrink table
    logic set_drop;
    logic res_load;  // load result register
  } nt_cmd_t;

  typedef struct packed {
    logic purge;
    logic at_end;    // idx == count
    logic full;
    logic hit;       // read id matches sender
    logic aged;      // read record is past age limit
    logic idx_zero;
    logic empty;
    logic out_free;
  } nt_sts_t;

endpackage

@@ rtl/nt_ram.sv @@
module nt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/nt_ctrl.sv @@
module nt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  nt_pkg::nt_sts_t sts,
  output nt_pkg::nt_cmd_t cmd
);

  import nt_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_START    = 4'd1;
  localparam logic [3:0] S_SRCH_RD  = 4'd2;
  localparam logic [3:0] S_SRCH_CMP = 4'd3;
  localparam logic [3:0] S_PRG_RD   = 4'd4;
  localparam logic [3:0] S_PRG_TEST = 4'd5;
  localparam logic [3:0] S_PRG_LAST = 4'd6;
  localparam logic [3:0] S_PRG_MOVE = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch   = 1'b1;
          cmd.idx_clr = 1'b1;
          state_nxt   = S_START;
        end
      end
      S_START: begin
        if (!sts.purge) begin
          state_nxt = S_SRCH_RD;
        end else if (sts.empty) begin
          state_nxt = S_DONE;
        end else begin
          cmd.idx_top = 1'b1;
          state_nxt   = S_PRG_RD;
        end
      end
      S_SRCH_RD: begin
        if (!sts.at_end) begin
          state_nxt = S_SRCH_CMP;
        end else begin
          // unknown sender: append or drop
          if (sts.full) begin
            cmd.set_drop = 1'b1;
          end else begin
            cmd.wr_new = 1'b1;
          end
          state_nxt = S_DONE;
        end
      end
      S_SRCH_CMP: begin
        if (sts.hit) begin
          cmd.wr_upd = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SRCH_RD;
        end
      end
      S_PRG_RD: begin
        state_nxt = S_PRG_TEST;
      end
      S_PRG_TEST: begin
        if (sts.aged) begin
          state_nxt = S_PRG_LAST;
        end else if (sts.idx_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.idx_dec = 1'b1;
          state_nxt   = S_PRG_RD;
        end
      end
      S_PRG_LAST: begin
        cmd.rd_last = 1'b1;
        state_nxt   = S_PRG_MOVE;
      end
      S_PRG_MOVE: begin
        cmd.wr_move = 1'b1;
        if (sts.idx_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.idx_dec = 1'b1;
          state_nxt   = S_PRG_RD;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/nt_dp.sv @@
`include "neighbor_table_with_aging_unit_macros.svh"

module nt_dp #(
  parameter int MAX_ENTRIES   = nt_pkg::NT_MAX_ENTRIES,
  parameter int HISTORY_DEPTH = nt_pkg::NT_HISTORY_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  nt_pkg::nt_cmd_t                cmd,
  output nt_pkg::nt_sts_t                sts,
  input  logic [nt_pkg::NT_TIME_W-1:0]   age_limit,
  input  logic                           in_action,
  input  logic [nt_pkg::NT_ID_W-1:0]     in_sender_id,
  input  logic [nt_pkg::NT_DIST_W-1:0]   in_distance,
  input  logic [nt_pkg::NT_BYTE_W-1:0]   in_sender_neighbor_count,
  input  logic [nt_pkg::NT_BYTE_W-1:0]   in_sender_state,
  input  logic [nt_pkg::NT_GRAD_W-1:0]   in_sender_gradient,
  input  logic [nt_pkg::NT_TIME_W-1:0]   in_now,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [nt_pkg::NT_OUT_W-1:0]    out_slot,
  output logic                           out_was_new,
  output logic                           out_dropped,
  output logic [nt_pkg::NT_OUT_W-1:0]    out_removed,
  output logic [nt_pkg::NT_OUT_W-1:0]    out_neighbor_count
);

  import nt_pkg::*;

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int PW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int RPT_W = NT_BYTE_W + NT_BYTE_W + NT_GRAD_W;

  // Record row: id | time | report | history pointer | distance history
  localparam int ID_LO   = 0;
  localparam int TIME_LO = ID_LO + NT_ID_W;
  localparam int RPT_LO  = TIME_LO + NT_TIME_W;
  localparam int PTR_LO  = RPT_LO + RPT_W;
  localparam int HIST_LO = PTR_LO + PW;
  localparam int ROW_W   = HIST_LO + NT_DIST_W * HISTORY_DEPTH;

  localparam logic [IW-1:0] CNT_MAX  = IW'(MAX_ENTRIES - 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(HISTORY_DEPTH - 1);

  // Captured item
  logic                 purge_r;
  logic [NT_ID_W-1:0]   id_r;
  logic [NT_DIST_W-1:0] dist_r;
  logic [RPT_W-1:0]     rpt_r;
  logic [NT_TIME_W-1:0] now_r;

  logic [IW-1:0] cnt_r;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] removed_r;
  logic          was_new_r;
  logic          dropped_r;

  logic                 out_valid_r;
  logic [NT_OUT_W-1:0]  out_slot_r;
  logic                 out_was_new_r;
  logic                 out_dropped_r;
  logic [NT_OUT_W-1:0]  out_removed_r;
  logic [NT_OUT_W-1:0]  out_count_r;

  logic                 ram_we;
  logic [IW-1:0]        ram_raddr;
  logic [ROW_W-1:0]     ram_wdata;
  logic [ROW_W-1:0]     rd_row;
  logic [ROW_W-1:0]     new_row;
  logic [ROW_W-1:0]     upd_row;
  logic [PW-1:0]        ptr_old;
  logic [PW-1:0]        ptr_new;
  logic [NT_TIME_W-1:0] age;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      purge_r <= (in_action == ACT_PURGE);
      id_r    <= in_sender_id;
      dist_r  <= in_distance;
      rpt_r   <= {in_sender_gradient, in_sender_state, in_sender_neighbor_count};
      now_r   <= in_now;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end else if (cmd.idx_top) begin
      idx_r <= cnt_r - 1'b1;
    end else if (cmd.idx_dec) begin
      idx_r <= idx_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.wr_new) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (cmd.wr_move) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      removed_r <= '0;
      was_new_r <= 1'b0;
      dropped_r <= 1'b0;
    end else begin
      if (cmd.wr_move) begin
        removed_r <= removed_r + 1'b1;
      end
      if (cmd.wr_new) begin
        was_new_r <= 1'b1;
      end
      if (cmd.set_drop) begin
        dropped_r <= 1'b1;
      end
    end
  end

  // Record rows
  assign ptr_old = rd_row[PTR_LO +: PW];
  assign ptr_new = (ptr_old < PTR_LAST) ? ptr_old + 1'b1 : '0;

  always_comb begin
    new_row = '0;
    new_row[ID_LO +: NT_ID_W]     = id_r;
    new_row[TIME_LO +: NT_TIME_W] = now_r;
    new_row[RPT_LO +: RPT_W]      = rpt_r;
    new_row[PTR_LO +: PW]         = '0;
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      new_row[HIST_LO + k*NT_DIST_W +: NT_DIST_W] = dist_r;
    end
  end

  always_comb begin
    upd_row = rd_row;
    upd_row[ID_LO +: NT_ID_W]     = id_r;
    upd_row[TIME_LO +: NT_TIME_W] = now_r;
    upd_row[RPT_LO +: RPT_W]      = rpt_r;
    upd_row[PTR_LO +: PW]         = ptr_new;
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      if (PW'(k) == ptr_new) begin
        upd_row[HIST_LO + k*NT_DIST_W +: NT_DIST_W] = dist_r;
      end
    end
  end

  assign ram_we    = cmd.wr_new | cmd.wr_upd | cmd.wr_move;
  assign ram_raddr = cmd.rd_last ? cnt_r - 1'b1 : idx_r;
  assign ram_wdata = cmd.wr_new ? new_row : (cmd.wr_upd ? upd_row : rd_row);

  nt_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_ENTRIES)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_row)
  );

  assign age = now_r - rd_row[TIME_LO +: NT_TIME_W];

  always_comb begin
    sts          = '0;
    sts.purge    = purge_r;
    sts.at_end   = (idx_r == cnt_r);
    sts.full     = (cnt_r == CNT_MAX);
    sts.hit      = (rd_row[ID_LO +: NT_ID_W] == id_r);
    sts.aged     = (age > age_limit);
    sts.idx_zero = (idx_r == '0);
    sts.empty    = (cnt_r == '0);
    sts.out_free = ~out_valid_r | out_ready;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_slot_r    <= (purge_r | dropped_r) ? '0 : NT_OUT_W'(idx_r);
      out_was_new_r <= was_new_r;
      out_dropped_r <= dropped_r;
      out_removed_r <= NT_OUT_W'(removed_r);
      out_count_r   <= NT_OUT_W'(cnt_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_slot           = out_slot_r;
  assign out_was_new        = out_was_new_r;
  assign out_dropped        = out_dropped_r;
  assign out_removed        = out_removed_r;
  assign out_neighbor_count = out_count_r;

  `NT_ASSERT_IMPLY(a_cnt_bound, 1'b1, cnt_r <= CNT_MAX, "table count past capacity")
  `NT_ASSERT_IMPLY(a_new_room, cmd.wr_new, cnt_r != CNT_MAX && idx_r == cnt_r, "append bad")
  `NT_ASSERT_NEXT(a_move_dec, cmd.wr_move, cnt_r == $past(cnt_r) - 1'b1, "move count slip")
  `NT_ASSERT_NEXT(a_load_valid, cmd.res_load, out_valid_r, "result not presented")

endmodule

@@ rtl/neighbor_table_with_aging_unit.sv @@
// Channel   Handshake           Payload
// in_       in_valid/in_ready   action, sender_id, distance, sender_neighbor_count,
//                               sender_state, sender_gradient, now
// out_      out_valid/out_ready slot, was_new, dropped, removed, neighbor_count
// config    psel/penable/pready paddr, pwdata, prdata (age_limit at byte 0)
//
// One item at a time. A message scans records from slot 0 until a hit, or to the
// end for an append or drop; a purge scans records from the top down. Every record
// access goes through the single read port of the record RAM (registered read), one
// access per scan step.
// Reset (rst_n low, synchronous) empties the table; no clearing pass.
// A result waits in the output register; the next item is taken meanwhile and
// its own result waits for that register to free up.

module neighbor_table_with_aging_unit #(
  parameter int MAX_ENTRIES   = nt_pkg::NT_MAX_ENTRIES,
  parameter int HISTORY_DEPTH = nt_pkg::NT_HISTORY_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input items
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [nt_pkg::NT_ID_W-1:0]     in_sender_id,
  input  logic [nt_pkg::NT_DIST_W-1:0]   in_distance,
  input  logic [nt_pkg::NT_BYTE_W-1:0]   in_sender_neighbor_count,
  input  logic [nt_pkg::NT_BYTE_W-1:0]   in_sender_state,
  input  logic [nt_pkg::NT_GRAD_W-1:0]   in_sender_gradient,
  input  logic [nt_pkg::NT_TIME_W-1:0]   in_now,
  // result items
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [nt_pkg::NT_OUT_W-1:0]    out_slot,
  output logic                           out_was_new,
  output logic                           out_dropped,
  output logic [nt_pkg::NT_OUT_W-1:0]    out_removed,
  output logic [nt_pkg::NT_OUT_W-1:0]    out_neighbor_count,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nt_pkg::NT_ADDR_W-1:0]   paddr,
  input  logic [nt_pkg::NT_DATA_W-1:0]   pwdata,
  output logic [nt_pkg::NT_DATA_W-1:0]   prdata,
  output logic                           pready
);

  import nt_pkg::*;

  logic [NT_TIME_W-1:0] age_limit_r;
  logic                 reg_hit;
  nt_cmd_t              cmd;
  nt_sts_t              sts;

  // Register decode: word index is paddr[2]; low bits ignored.
  assign reg_hit = (paddr[2] == REG_AGE_LIMIT);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? age_limit_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_limit_r <= NT_AGE_LIMIT_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      age_limit_r <= pwdata;
    end
  end

  // Sequencer: search, append/refresh, purge scan and result hand-off.
  nt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Record RAM, counters, compares and result register.
  nt_dp #(
    .MAX_ENTRIES   (MAX_ENTRIES),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cmd                      (cmd),
    .sts                      (sts),
    .age_limit                (age_limit_r),
    .in_action                (in_action),
    .in_sender_id             (in_sender_id),
    .in_distance              (in_distance),
    .in_sender_neighbor_count (in_sender_neighbor_count),
    .in_sender_state          (in_sender_state),
    .in_sender_gradient       (in_sender_gradient),
    .in_now                   (in_now),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_slot                 (out_slot),
    .out_was_new              (out_was_new),
    .out_dropped              (out_dropped),
    .out_removed              (out_removed),
    .out_neighbor_count       (out_neighbor_count)
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import nt_pkg::*;

  // Table holds one record less than its storage depth.
  localparam int TABLE_CAP   = NT_MAX_ENTRIES - 1;
  // Watchdog limit, set well above the longest run.
  localparam int CYCLE_LIMIT = 1000000;
  // Enough for a full purge scan to finish.
  localparam int SETTLE      = 80;
  localparam int MAX_REPORTS = 50;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  // One input item, plus a flag that holds it back until all results are in.
  typedef struct {
    logic                 action;
    logic [NT_ID_W-1:0]   sender_id;
    logic [NT_DIST_W-1:0] distance;
    logic [NT_BYTE_W-1:0] ncount;
    logic [NT_BYTE_W-1:0] bstate;
    logic [NT_GRAD_W-1:0] gradient;
    logic [NT_TIME_W-1:0] now;
    bit                   hold;
  } nbr_item_t;

  typedef struct {
    logic [NT_OUT_W-1:0] slot;
    logic                was_new;
    logic                dropped;
    logic [NT_OUT_W-1:0] removed;
    logic [NT_OUT_W-1:0] count;
  } nbr_result_t;

  // Clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // DUT ports, inputs at known values from time zero
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_action = ACT_MSG;
  logic [NT_ID_W-1:0]   in_sender_id = '0;
  logic [NT_DIST_W-1:0] in_distance = '0;
  logic [NT_BYTE_W-1:0] in_sender_neighbor_count = '0;
  logic [NT_BYTE_W-1:0] in_sender_state = '0;
  logic [NT_GRAD_W-1:0] in_sender_gradient = '0;
  logic [NT_TIME_W-1:0] in_now = '0;

  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [NT_OUT_W-1:0]  out_slot;
  logic                 out_was_new;
  logic                 out_dropped;
  logic [NT_OUT_W-1:0]  out_removed;
  logic [NT_OUT_W-1:0]  out_neighbor_count;

  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [NT_ADDR_W-1:0] paddr = '0;
  logic [NT_DATA_W-1:0] pwdata = '0;
  logic [NT_DATA_W-1:0] prdata;
  logic                 pready;

  neighbor_table_with_aging_unit u_dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_action                (in_action),
    .in_sender_id             (in_sender_id),
    .in_distance              (in_distance),
    .in_sender_neighbor_count (in_sender_neighbor_count),
    .in_sender_state          (in_sender_state),
    .in_sender_gradient       (in_sender_gradient),
    .in_now                   (in_now),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_slot                 (out_slot),
    .out_was_new              (out_was_new),
    .out_dropped              (out_dropped),
    .out_removed              (out_removed),
    .out_neighbor_count       (out_neighbor_count),
    .psel                     (psel),
    .penable                  (penable),
    .pwrite                   (pwrite),
    .paddr                    (paddr),
    .pwdata                   (pwdata),
    .prdata                   (prdata),
    .pready                   (pready)
  );

  // Item stream and expected results
  nbr_item_t   item_fifo[$];
  nbr_result_t result_fifo[$];
  idle_mode_t  idle_mode = IDLE_NONE;

  int errors       = 0;
  int items_in     = 0;
  int results_out  = 0;
  int n_purge      = 0;
  int n_new        = 0;
  int n_hit        = 0;
  int n_drop       = 0;
  int n_purged     = 0;
  int cycle_count  = 0;

  logic [NT_TIME_W-1:0] sim_now = '0;  // running tick used by the generator

  // ---------------------------------------------------------------------------
  // Neighbor table predictor. Only ids, timestamps and the record count reach
  // the result fields; distance history and reports are never observable.
  // ---------------------------------------------------------------------------
  logic [NT_ID_W-1:0]   tbl_id   [NT_MAX_ENTRIES];
  logic [NT_TIME_W-1:0] tbl_time [NT_MAX_ENTRIES];
  int                   tbl_count = 0;
  logic [NT_TIME_W-1:0] age_limit_q = NT_AGE_LIMIT_RST;

  function automatic nbr_result_t table_apply(nbr_item_t it);
    nbr_result_t r;
    int i;
    logic [NT_TIME_W-1:0] age;
    r = '{default: '0};
    if (it.action == ACT_MSG) begin
      // linear search by sender id
      i = 0;
      while (i < tbl_count && tbl_id[i] != it.sender_id) i++;
      if (i == tbl_count) begin
        if (tbl_count < TABLE_CAP) begin
          tbl_count++;
          r.was_new = 1'b1;
          n_new++;
        end else begin
          // unknown sender, table full: nothing changes
          r.dropped = 1'b1;
          n_drop++;
        end
      end else begin
        n_hit++;
      end
      if (!r.dropped) begin
        tbl_id[i]   = it.sender_id;
        tbl_time[i] = it.now;
        r.slot      = NT_OUT_W'(i);
      end
    end else begin
      // scan top down; the last record fills each freed slot
      for (i = tbl_count - 1; i >= 0; i--) begin
        age = it.now - tbl_time[i];  // wraps modulo 2^32
        if (age > age_limit_q) begin
          tbl_id[i]   = tbl_id[tbl_count - 1];
          tbl_time[i] = tbl_time[tbl_count - 1];
          tbl_count--;
          r.removed++;
          n_purged++;
        end
      end
      n_purge++;
    end
    r.count = NT_OUT_W'(tbl_count);
    return r;
  endfunction

  function automatic bit send_gap();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(0, 99) < 66;
      IDLE_BOTH: return $urandom_range(0, 99) < 6;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit recv_stall();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(0, 99) < 66;
      IDLE_BOTH: return $urandom_range(0, 99) < 6;
      default:   return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: predicts on acceptance, then presents the next pending item.
  // An item flagged hold waits until every expected result has come back.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    nbr_item_t cur;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        result_fifo.push_back(table_apply(cur));
        items_in++;
      end
      if (!in_valid || in_ready) begin
        if (item_fifo.size() != 0 && !(item_fifo[0].hold && result_fifo.size() != 0) &&
            !send_gap()) begin
          cur = item_fifo.pop_front();
          in_action                <= cur.action;
          in_sender_id             <= cur.sender_id;
          in_distance              <= cur.distance;
          in_sender_neighbor_count <= cur.ncount;
          in_sender_state          <= cur.bstate;
          in_sender_gradient       <= cur.gradient;
          in_now                   <= cur.now;
          in_valid                 <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: compares each accepted result with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    nbr_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_out++;
        if (result_fifo.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, actual slot %0d count %0d",
                     $time, out_slot, out_neighbor_count);
        end else begin
          want = result_fifo.pop_front();
          check_field("slot", want.slot, out_slot);
          check_field("was_new", want.was_new, out_was_new);
          check_field("dropped", want.dropped, out_dropped);
          check_field("removed", want.removed, out_removed);
          check_field("neighbor_count", want.count, out_neighbor_count);
        end
      end
      out_ready <= !recv_stall();
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, result_fifo.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_item(input logic act, input logic [NT_ID_W-1:0] id,
                                    input logic [NT_DIST_W-1:0] dval,
                                    input logic [NT_BYTE_W-1:0] nc,
                                    input logic [NT_BYTE_W-1:0] st,
                                    input logic [NT_GRAD_W-1:0] grad,
                                    input logic [NT_TIME_W-1:0] now, input bit hold);
    nbr_item_t it;
    it.action    = act;
    it.sender_id = id;
    it.distance  = dval;
    it.ncount    = nc;
    it.bstate    = st;
    it.gradient  = grad;
    it.now       = now;
    it.hold      = hold;
    item_fifo.push_back(it);
  endfunction

  // Message with random report content
  function automatic void push_msg(input logic [NT_ID_W-1:0] id,
                                   input logic [NT_TIME_W-1:0] now, input bit hold);
    push_item(ACT_MSG, id, NT_DIST_W'($urandom), NT_BYTE_W'($urandom),
              NT_BYTE_W'($urandom), NT_GRAD_W'($urandom), now, hold);
  endfunction

  // Purge; the fields it ignores carry random noise
  function automatic void push_purge(input logic [NT_TIME_W-1:0] now, input bit hold);
    push_item(ACT_PURGE, NT_ID_W'($urandom), NT_DIST_W'($urandom), NT_BYTE_W'($urandom),
              NT_BYTE_W'($urandom), NT_GRAD_W'($urandom), now, hold);
  endfunction

  // APB write: setup cycle, then access until pready
  task automatic cfg_write(input logic [NT_ADDR_W-1:0] addr, input logic [NT_DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == {REG_AGE_LIMIT, 2'b00}) age_limit_q = data;
  endtask

  task automatic wait_idle();
    while (item_fifo.size() != 0 || in_valid || result_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Directed items, run with the reset age limit of 64.
  task automatic gen_directed();
    int k;
    push_purge(32'd0, 1'b0);                                      // purge on empty table
    push_item(ACT_MSG, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000, 32'd0, 1'b0);
    push_item(ACT_MSG, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    push_msg(16'h0000, 32'd10, 1'b0);                             // refresh, hit at slot 0
    for (k = 1; k <= 13; k++) push_msg(NT_ID_W'(k), 32'(20 + k), 1'b0);  // fill to capacity
    push_msg(16'h1234, 32'd40, 1'b0);                             // unknown sender, full table
    push_msg(16'h0005, 32'd41, 1'b0);                             // hit while full
    push_purge(32'd70, 1'b1);                                     // age wraps past 2^32
    push_purge(32'h0000_0010, 1'b0);                              // now behind timestamps
    push_msg(16'hFFFF, 32'd100, 1'b1);
    push_purge(32'd164, 1'b0);                                    // age equals limit: kept
    push_purge(32'd165, 1'b0);                                    // one past the limit
  endtask

  // Mostly messages from a small pool of ids so hits, appends and drops all
  // happen; the rest are random ids, purges and jumps of the tick counter.
  task automatic gen_random(input int n, input int step);
    logic [NT_ID_W-1:0] pool [24];
    logic [NT_ID_W-1:0] id;
    int k;
    bit hold;
    for (k = 0; k < 24; k++) pool[k] = NT_ID_W'($urandom);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 19) == 0) sim_now = $urandom;
      else sim_now = sim_now + $urandom_range(0, step);
      hold = $urandom_range(0, 59) == 0;
      if ($urandom_range(0, 99) < 12) begin
        push_purge(sim_now, hold);
      end else begin
        if ($urandom_range(0, 99) < 80) id = pool[$urandom_range(0, 23)];
        else id = NT_ID_W'($urandom);
        push_msg(id, sim_now, hold);
      end
    end
  endtask

  task automatic run_phase(input logic [NT_DATA_W-1:0] limit, input int step,
                           input idle_mode_t mode, input logic [NT_TIME_W-1:0] start);
    cfg_write({REG_AGE_LIMIT, 2'b00}, limit);
    idle_mode = mode;
    sim_now   = start;
    gen_random(240, step);
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gen_directed();
    wait_idle();

    // Age limit extremes first, then other values; idle patterns cycle through the four modes.
    run_phase(32'h0000_0000, 3,           IDLE_NONE, 32'd0);
    run_phase(32'hFFFF_FFFF, 1000,        IDLE_SEND, $urandom);
    run_phase(32'd64,        16,          IDLE_RECV, 32'hFFFF_FF80);
    run_phase($urandom_range(20, 300), 40, IDLE_BOTH, $urandom);
    run_phase($urandom,      100000,      IDLE_NONE, $urandom);
    run_phase(32'd1,         2,           IDLE_SEND, 32'hFFFF_FFF0);
    run_phase(32'h8000_0000, 32'h1000_0000, IDLE_RECV, $urandom);
    run_phase($urandom_range(100, 1000), 200, IDLE_BOTH, 32'hFFFF_F000);

    $display("Covered %0d items (%0d purges) and %0d results over 8 age limit settings;",
             items_in, n_purge, results_out);
    $display("  %0d appends, %0d refreshes, %0d drops on a full table, %0d records aged out",
             n_new, n_hit, n_drop, n_purged);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
